>>> rtl/ccp_pkg.sv
// Shared types, constants and helpers for the CRC codeword packer.
package ccp_pkg;

  localparam int POLY_BITS       = 17;
  localparam int GEN_MAX_BITS    = 17;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 32;
  localparam int LEN_REG_BITS    = 5;
  localparam int STREAM_LEN_BITS = 32;

  localparam logic [POLY_BITS-1:0]       GEN_POLY_RESET    = 17'd11;
  localparam logic [LEN_REG_BITS-1:0]    GEN_LENGTH_RESET  = 5'd4;
  localparam logic                       DW_MODE_RESET     = 1'b1;
  localparam logic [STREAM_LEN_BITS-1:0] INPUT_LENGTH_RESET = '0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GEN_POLY      = 2'd0,
    REG_GEN_LENGTH    = 2'd1,
    REG_DATAWORD_MODE = 2'd2,
    REG_INPUT_LENGTH  = 2'd3
  } cfg_reg_e;

  // Per-byte control word handed from the front to the back.
  typedef struct packed {
    logic       hdr;        // send header byte and padding first
    logic [2:0] pad;        // padding count for the header
    logic       two_words;  // 4-bit mode: two codewords for this byte
    logic       eos;        // this byte closes the stream
  } ccp_ctrl_t;

  // Widest generator the block supports.
  function automatic int eff_gen_bits(input int max_bits);
    return (max_bits < POLY_BITS) ? max_bits : POLY_BITS;
  endfunction

endpackage

>>> rtl/ccp_if.sv
// Channel interfaces: input bytes, output bytes and configuration writes.
interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ccp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

interface ccp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ccp_pkg::CFG_INDEX_BITS-1:0] index;
  logic [ccp_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/crc_codeword_packer.sv
// Top level of the CRC codeword packer: front end, queue and bit packer.
// Each input byte becomes one 8-bit or two 4-bit datawords, each extended by
// its CRC remainder and packed MSB first into output bytes; the first byte of
// a stream is preceded by a header byte with the padding count, and the final
// byte of a stream (set by input_length) carries last. The front end takes one
// byte per cycle while the two-entry queue has room. The bit packer delivers
// one output byte per cycle through its output register while the receiver is
// ready; an item yields at most seven output bytes, header and final flush
// included, and a dataword whose bits do not yet complete a byte takes a step
// of its own with no output byte. Throughput is set by the byte-wide output
// port of the packer. Configuration writes are taken every cycle; there is no
// start-up sweep after reset.
module crc_codeword_packer #(
  parameter int GenMaxBits = ccp_pkg::GEN_MAX_BITS,
  parameter int QueueDepth = ccp_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccp_in_if.sink    data_i,
  ccp_out_if.source data_o,
  ccp_cfg_if.sink   cfg_i
);

  localparam int GenW   = ccp_pkg::eff_gen_bits(GenMaxBits);
  localparam int CwW    = 8 + GenW - 1;
  localparam int LenW   = $clog2(CwW + 1);
  localparam int CtrlW  = $bits(ccp_pkg::ccp_ctrl_t);
  localparam int EntryW = CtrlW + LenW + 2 * CwW;

  // Front side of the queue.
  logic               push, queue_ready;
  ccp_pkg::ccp_ctrl_t f_ctrl;
  logic [LenW-1:0]    f_len;
  logic [CwW-1:0]     f_cw0, f_cw1;

  // Back side of the queue.
  logic               head_valid, pop;
  logic [EntryW-1:0]  head_data;
  ccp_pkg::ccp_ctrl_t b_ctrl;
  logic [LenW-1:0]    b_len;
  logic [CwW-1:0]     b_cw0, b_cw1;

  // Accept and classify: stream position, header, padding and codewords.
  ccp_front #(
    .GenMaxBits(GenMaxBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_i        (data_i),
    .cfg_i         (cfg_i),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .ctrl_o        (f_ctrl),
    .len_o         (f_len),
    .cw0_o         (f_cw0),
    .cw1_o         (f_cw1)
  );

  // Hold classified bytes so either side can stall on its own.
  ccp_fifo #(
    .Width(EntryW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  ({f_ctrl, f_len, f_cw0, f_cw1}),
    .ready_o      (queue_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  assign {b_ctrl, b_len, b_cw0, b_cw1} = head_data;

  // Pack codeword bits into bytes and drive the output transfer.
  ccp_back #(
    .GenMaxBits(GenMaxBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .ctrl_i       (b_ctrl),
    .len_i        (b_len),
    .cw0_i        (b_cw0),
    .cw1_i        (b_cw1),
    .pop_o        (pop),
    .data_o       (data_o)
  );

endmodule

>>> rtl/ccp_fifo.sv
// Short queue of classified input bytes between front and back.
module ccp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [Width-1:0] head_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign ready_o      = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/ccp_front.sv
// Front end: configuration registers, stream tracking and codeword generation.
module ccp_front #(
  parameter int GenMaxBits = ccp_pkg::GEN_MAX_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ccp_in_if.sink                    data_i,
  ccp_cfg_if.sink                   cfg_i,
  input  logic                      queue_ready_i,
  output logic                      push_o,
  output ccp_pkg::ccp_ctrl_t        ctrl_o,
  output logic [$clog2(8 + ccp_pkg::eff_gen_bits(GenMaxBits))-1:0] len_o,
  output logic [8 + ccp_pkg::eff_gen_bits(GenMaxBits) - 2:0]       cw0_o,
  output logic [8 + ccp_pkg::eff_gen_bits(GenMaxBits) - 2:0]       cw1_o
);

  localparam int GenW = ccp_pkg::eff_gen_bits(GenMaxBits);
  localparam int CwW  = 8 + GenW - 1;
  localparam int LenW = $clog2(CwW + 1);

  logic [ccp_pkg::POLY_BITS-1:0]       poly_q;
  logic [ccp_pkg::LEN_REG_BITS-1:0]    glen_q;
  logic                                mode_q;
  logic [ccp_pkg::STREAM_LEN_BITS-1:0] ilen_q;
  logic [ccp_pkg::STREAM_LEN_BITS-1:0] bytes_seen_q, bytes_seen_d;
  logic                                header_done_q;

  logic [4:0]     g_eff, gm1;
  logic [3:0]     n_bits;
  logic [CwW-1:0] poly_m;
  logic [7:0]     d0, d1;
  logic [2:0]     kc;
  logic [5:0]     prod;
  logic           eos;

  // Systematic codeword: dataword followed by the mod-2 remainder.
  function automatic logic [CwW-1:0] make_cw(input logic [7:0] d, input logic [3:0] n,
                                             input logic [4:0] sh, input logic [CwW-1:0] poly);
    logic [CwW-1:0] rem;
    logic [CwW-1:0] top;
    rem = CwW'(d) << sh;
    for (int i = 7; i >= 0; i--) begin
      top = rem >> (sh + 5'(i));
      if ((i < int'(n)) && top[0]) begin
        rem = rem ^ (poly << i);
      end
    end
    return (CwW'(d) << sh) | (rem & ((CwW'(1) << sh) - CwW'(1)));
  endfunction

  assign cfg_i.ready  = 1'b1;
  assign data_i.ready = queue_ready_i;
  assign push_o       = data_i.valid && queue_ready_i;

  always_comb begin
    if (glen_q < 5'd2) begin
      g_eff = 5'd2;
    end else if (glen_q > 5'(GenW)) begin
      g_eff = 5'(GenW);
    end else begin
      g_eff = glen_q;
    end
    gm1    = g_eff - 5'd1;
    n_bits = mode_q ? 4'd8 : 4'd4;
    poly_m = CwW'(poly_q[GenW-1:0]) & ((CwW'(1) << g_eff) - CwW'(1));
    d0     = mode_q ? data_i.data_byte : {4'b0, data_i.data_byte[7:4]};
    d1     = {4'b0, data_i.data_byte[3:0]};
    len_o  = LenW'(n_bits) + LenW'(gm1);
    cw0_o  = make_cw(d0, n_bits, gm1, poly_m);
    cw1_o  = make_cw(d1, n_bits, gm1, poly_m);
    // Only the low three bits of k * len * input_length set the padding.
    kc     = mode_q ? len_o[2:0] : {len_o[1:0], 1'b0};
    prod   = kc * ilen_q[2:0];
    eos    = (ilen_q != '0) && ((bytes_seen_q + 1'b1) == ilen_q);
    bytes_seen_d = eos ? '0 : bytes_seen_q + 1'b1;
    ctrl_o.hdr       = !header_done_q;
    ctrl_o.pad       = 3'd0 - prod[2:0];
    ctrl_o.two_words = !mode_q;
    ctrl_o.eos       = eos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= ccp_pkg::GEN_POLY_RESET;
      glen_q <= ccp_pkg::GEN_LENGTH_RESET;
      mode_q <= ccp_pkg::DW_MODE_RESET;
      ilen_q <= ccp_pkg::INPUT_LENGTH_RESET;
    end else if (cfg_i.valid) begin
      case (ccp_pkg::cfg_reg_e'(cfg_i.index))
        ccp_pkg::REG_GEN_POLY:      poly_q <= cfg_i.data[ccp_pkg::POLY_BITS-1:0];
        ccp_pkg::REG_GEN_LENGTH:    glen_q <= cfg_i.data[ccp_pkg::LEN_REG_BITS-1:0];
        ccp_pkg::REG_DATAWORD_MODE: mode_q <= cfg_i.data[0];
        ccp_pkg::REG_INPUT_LENGTH:  ilen_q <= cfg_i.data;
        default:                    poly_q <= poly_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q  <= '0;
      header_done_q <= 1'b0;
    end else if (push_o) begin
      bytes_seen_q  <= bytes_seen_d;
      header_done_q <= !eos;
    end
  end

endmodule

>>> rtl/ccp_back.sv
// Back end: bit packer that turns queued codewords into output bytes.
module ccp_back #(
  parameter int GenMaxBits = ccp_pkg::GEN_MAX_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  ccp_pkg::ccp_ctrl_t        ctrl_i,
  input  logic [$clog2(8 + ccp_pkg::eff_gen_bits(GenMaxBits))-1:0] len_i,
  input  logic [8 + ccp_pkg::eff_gen_bits(GenMaxBits) - 2:0]       cw0_i,
  input  logic [8 + ccp_pkg::eff_gen_bits(GenMaxBits) - 2:0]       cw1_i,
  output logic                      pop_o,
  ccp_out_if.source                 data_o
);

  localparam int GenW = ccp_pkg::eff_gen_bits(GenMaxBits);
  localparam int CwW  = 8 + GenW - 1;
  localparam int AccW = CwW + 7;
  localparam int CntW = $clog2(AccW + 1);

  logic [AccW-1:0] acc_q, acc_d, a_acc, shifted;
  logic [CntW-1:0] cnt_q, cnt_d, a_cnt;
  logic [1:0]      idx_q, idx_d, idx, words;
  logic            hdr_sent_q, hdr_sent_d;
  logic            advance, emit, emit_last;
  logic [7:0]      emit_byte;
  logic [2:0]      flush_sh;
  logic [CwW-1:0]  cw_sel;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  assign data_o.valid    = out_valid_q;
  assign data_o.out_byte = out_byte_q;
  assign data_o.last     = out_last_q;

  // Work only while the output register is free or draining this cycle.
  assign advance = head_valid_i && (!out_valid_q || data_o.ready);

  always_comb begin
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    hdr_sent_d = hdr_sent_q;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_byte  = '0;
    pop_o      = 1'b0;
    words      = ctrl_i.two_words ? 2'd2 : 2'd1;
    a_acc      = acc_q;
    a_cnt      = cnt_q;
    idx        = idx_q;
    cw_sel     = (idx_q == 2'd0) ? cw0_i : cw1_i;
    shifted    = '0;
    flush_sh   = '0;
    if (advance) begin
      if (ctrl_i.hdr && !hdr_sent_q) begin
        // Header byte, then restart packing with pad zero bits.
        emit       = 1'b1;
        emit_byte  = {5'b0, ctrl_i.pad};
        acc_d      = '0;
        cnt_d      = CntW'(ctrl_i.pad);
        hdr_sent_d = 1'b1;
      end else begin
        if ((a_cnt < CntW'(8)) && (idx < words)) begin
          a_acc = (a_acc << len_i) | AccW'(cw_sel);
          a_cnt = a_cnt + CntW'(len_i);
          idx   = idx + 2'd1;
        end
        if (a_cnt >= CntW'(8)) begin
          shifted   = a_acc >> (a_cnt - CntW'(8));
          emit      = 1'b1;
          emit_byte = shifted[7:0];
          a_cnt     = a_cnt - CntW'(8);
          a_acc     = a_acc & ((AccW'(1) << a_cnt) - AccW'(1));
          emit_last = ctrl_i.eos && (idx == words) && (a_cnt == '0);
        end else if ((idx == words) && ctrl_i.eos && (a_cnt != '0)) begin
          // Flush the partial byte, zero filled, to close the stream.
          flush_sh  = 3'd0 - a_cnt[2:0];
          emit      = 1'b1;
          emit_byte = a_acc[7:0] << flush_sh;
          emit_last = 1'b1;
          a_cnt     = '0;
          a_acc     = '0;
        end
        acc_d = a_acc;
        cnt_d = a_cnt;
        if ((idx == words) && (a_cnt < CntW'(8)) && !(ctrl_i.eos && (a_cnt != '0))) begin
          pop_o      = 1'b1;
          idx_d      = 2'd0;
          hdr_sent_d = 1'b0;
        end else begin
          idx_d = idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      hdr_sent_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      hdr_sent_q <= hdr_sent_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        out_last_q  <= emit_last;
      end else if (data_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
    end
  end

  // A stalled output holds the packer still.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !data_o.ready) |-> (!emit && !pop_o))
    else $error("packer advanced while output stalled");

  // The closing byte leaves no pending bits behind.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (cnt_q == '0) && (acc_q == '0))
    else $error("pending bits left after last byte");

  // Between items fewer than a byte of bits may wait.
  a_idle_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (cnt_q < CntW'(8)) && (idx_q == 2'd0) && !hdr_sent_q)
    else $error("packer state not clean between items");

endmodule

>>> dv/tb_crc_codeword_packer.sv
// Self-checking testbench for the CRC codeword packer: directed and random streams.
module tb_crc_codeword_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POLY_BITS       = ccp_pkg::POLY_BITS;
  localparam int LEN_REG_BITS    = ccp_pkg::LEN_REG_BITS;
  localparam int STREAM_LEN_BITS = ccp_pkg::STREAM_LEN_BITS;
  localparam int GEN_MAX_BITS    = ccp_pkg::GEN_MAX_BITS;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 6;
  // The packer drains at most seven bytes per item through a two-entry queue;
  // this many quiet cycles after the last byte covers anything still in flight.
  localparam int SETTLE_CYCLES = 16;
  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 26;

  localparam logic [7:0] NIBBLE_HI = 8'hF0;
  localparam logic [7:0] NIBBLE_LO = 8'h0F;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } coded_t;

  logic clk;
  logic rst_n;

  ccp_in_if  in_ch ();
  ccp_out_if out_ch ();
  ccp_cfg_if cfg_ch ();

  crc_codeword_packer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .data_i (in_ch),
    .data_o (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Mirror of the configuration registers, updated on each accepted write.
  logic [POLY_BITS-1:0]       gen_poly;
  logic [LEN_REG_BITS-1:0]    gen_len;
  logic                       dw_mode;
  logic [STREAM_LEN_BITS-1:0] stream_len;

  // Mirror of the packing state: leftover bits, their count, bytes taken in
  // the current stream and whether the header has gone out.
  logic [6:0]                 pk_bits;
  logic [2:0]                 pk_cnt;
  logic [STREAM_LEN_BITS-1:0] pk_seen;
  logic                       pk_hdr_sent;

  // Coded bytes still owed by the block, oldest first.
  coded_t coded_q[$];

  int err_count    = 0;
  int src_idle_pct = 24;
  int snk_idle_pct = 78;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic coded_t coded(input logic [7:0] b, input logic l);
    coded_t c;
    c.out_byte = b;
    c.last     = l;
    return c;
  endfunction

  // Generator length actually used: clamp to 2..min(POLY_BITS, GEN_MAX_BITS).
  function automatic int eff_gen_len();
    int g;
    int hi;
    hi = (GEN_MAX_BITS < POLY_BITS) ? GEN_MAX_BITS : POLY_BITS;
    g  = int'(gen_len);
    if (g < 2) g = 2;
    if (g > hi) g = hi;
    return g;
  endfunction

  // Systematic codeword: dataword followed by the g-1 bit modulo-2 remainder.
  // A generator without its leading one is still XORed in on every set top
  // bit; anything above the remainder is dropped.
  function automatic logic [63:0] crc_codeword(input logic [7:0] d, input int n, input int g);
    logic [63:0] poly;
    logic [63:0] rem;
    poly = 64'(gen_poly) & ((64'd1 << g) - 64'd1);
    rem  = 64'(d) << (g - 1);
    for (int i = n - 1; i >= 0; i--) begin
      if (rem[i + g - 1]) rem ^= poly << i;
    end
    return (64'(d) << (g - 1)) | (rem & ((64'd1 << (g - 1)) - 64'd1));
  endfunction

  // Work out every coded byte that one input byte causes and queue them.
  task automatic pack_byte(input logic [7:0] b);
    coded_t      step_q[$];
    coded_t      tail;
    logic [63:0] acc;
    logic [63:0] prod;
    logic [7:0]  words[2];
    int          g;
    int          n_bits;
    int          cw;
    int          cnt;
    int          nw;
    int          pad;
    g      = eff_gen_len();
    n_bits = dw_mode ? 8 : 4;
    cw     = n_bits + g - 1;
    acc    = 64'(pk_bits);
    cnt    = int'(pk_cnt);
    // Stream start: header with the padding count, then that many zero bits.
    if (!pk_hdr_sent) begin
      prod = (dw_mode ? 64'd1 : 64'd2) * 64'(cw) * 64'(stream_len);
      pad  = (8 - int'(prod % 64'd8)) % 8;
      step_q.push_back(coded(8'(pad), 1'b0));
      acc         = '0;
      cnt         = pad;
      pk_hdr_sent = 1'b1;
    end
    if (dw_mode) begin
      words[0] = b;
      nw       = 1;
    end else begin
      words[0] = (b & NIBBLE_HI) >> 4;
      words[1] = b & NIBBLE_LO;
      nw       = 2;
    end
    for (int w = 0; w < nw; w++) begin
      acc = (acc << cw) | crc_codeword(words[w], n_bits, g);
      cnt += cw;
      while (cnt >= 8) begin
        step_q.push_back(coded(8'(acc >> (cnt - 8)), 1'b0));
        cnt -= 8;
        acc &= (64'd1 << cnt) - 64'd1;
      end
    end
    pk_seen = pk_seen + 1'b1;
    // Stream end: flush leftover bits zero-filled, flag the final byte, and
    // start over with a fresh header on the next byte.
    if (stream_len != '0 && pk_seen == stream_len) begin
      if (cnt > 0) step_q.push_back(coded(8'(acc << (8 - cnt)), 1'b0));
      if (step_q.size() > 0) begin
        tail      = step_q.pop_back();
        tail.last = 1'b1;
        step_q.push_back(tail);
      end
      acc         = '0;
      cnt         = 0;
      pk_seen     = '0;
      pk_hdr_sent = 1'b0;
    end
    pk_bits = acc[6:0];
    pk_cnt  = 3'(cnt);
    foreach (step_q[i]) coded_q.push_back(step_q[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t ns mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
    err_count++;
  endtask

  // Offer one byte, idling first at the sender's rate, and hold it until the
  // transfer; valid stays high so the next byte can follow without a gap.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    pack_byte(b);
  endtask

  // Random bytes, with the all-zero and all-one bytes showing up more often.
  task automatic send_random(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      send_byte(b);
    end
  endtask

  // Drop valid, wait for every owed byte, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ccp_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      ccp_pkg::REG_GEN_POLY:      gen_poly   = val[POLY_BITS-1:0];
      ccp_pkg::REG_GEN_LENGTH:    gen_len    = val[LEN_REG_BITS-1:0];
      ccp_pkg::REG_DATAWORD_MODE: dw_mode    = val[0];
      ccp_pkg::REG_INPUT_LENGTH:  stream_len = val[STREAM_LEN_BITS-1:0];
      default: ;
    endcase
  endtask

  // Write all four registers back to back; call only while the block is idle.
  task automatic program_regs(input logic [POLY_BITS-1:0] poly, input logic [4:0] glen,
                              input logic mode, input logic [31:0] len);
    write_reg(ccp_pkg::REG_GEN_POLY, 32'(poly));
    write_reg(ccp_pkg::REG_GEN_LENGTH, 32'(glen));
    write_reg(ccp_pkg::REG_DATAWORD_MODE, 32'(mode));
    write_reg(ccp_pkg::REG_INPUT_LENGTH, len);
    cfg_ch.valid <= 1'b0;
  endtask

  // Retarget the stream length so the open stream ends after more bytes.
  task automatic close_stream(input int unsigned remaining);
    program_regs(gen_poly, gen_len, dw_mode, pk_seen + remaining);
  endtask

  // Register defaults after reset, an all-one byte in the middle of a stream,
  // and a stream left open and then closed by a length written mid-stream.
  task automatic test_reset_state();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h80);
    drain();
    close_stream(1);
    send_byte(8'h01);
    drain();
  endtask

  // 4-bit datawords with the widest generator (most bytes per item) and the
  // narrowest one.
  task automatic test_nibble_mode();
    program_regs(17'h11021, 5'd17, 1'b0, 32'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    drain();
    program_regs(17'h00003, 5'd2, 1'b0, 32'd2);
    send_byte(8'h0F);
    send_byte(8'hF0);
    drain();
  endtask

  // Generator lengths outside 2..17 and generators missing their leading one.
  task automatic test_clamped_generator();
    program_regs(17'h1FFFF, 5'd0, 1'b1, 32'd2);
    send_byte(8'h80);
    send_byte(8'h7F);
    drain();
    program_regs(17'h00000, 5'd31, 1'b1, 32'd2);
    send_byte(8'hFF);
    send_byte(8'h01);
    drain();
    program_regs(17'h00005, 5'd1, 1'b0, 32'd1);
    send_byte(8'hC3);
    drain();
    program_regs(17'h00005, 5'd8, 1'b0, 32'd1);
    send_byte(8'h3C);
    drain();
  endtask

  // One-byte streams back to back, then the longest stream length, closed early.
  task automatic test_stream_lengths();
    program_regs(17'h0000B, 5'd4, 1'b1, 32'd1);
    send_byte(8'h12);
    send_byte(8'h34);
    drain();
    program_regs(17'h0001D, 5'd5, 1'b1, 32'hFFFF_FFFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    drain();
    close_stream(1);
    send_byte(8'h66);
    drain();
  endtask

  // Random settings and short well-formed streams under each idling pattern;
  // now and then a stream is opened with length zero and reconfigured midway.
  task automatic test_random_streams();
    int                   src_pct[3];
    int                   snk_pct[3];
    int                   items;
    int                   n;
    int                   r;
    logic [POLY_BITS-1:0] poly;
    logic [4:0]           glen;
    logic                 mode;
    src_pct = '{24, 78, 0};
    snk_pct = '{78, 24, 0};
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = src_pct[ph];
      snk_idle_pct = snk_pct[ph];
      items        = 0;
      while (items < RANDOM_ITEMS) begin
        glen = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(2, 17));
        poly = POLY_BITS'($urandom_range(0, 32'h1FFFF));
        // Mostly proper generators: set the leading one when it is in range.
        if (glen >= 2 && glen <= 17 && $urandom_range(0, 3) != 0) poly |= 17'd1 << (glen - 1);
        mode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) begin
          program_regs(poly, glen, mode, 32'd0);
          n = $urandom_range(1, 3);
          send_random(n);
          drain();
          r = $urandom_range(1, 3);
          program_regs(poly, 5'($urandom_range(2, 17)), 1'($urandom_range(0, 1)), pk_seen + r);
          send_random(r);
          drain();
          items += n + r;
        end else begin
          n = $urandom_range(1, 6);
          program_regs(poly, glen, mode, 32'(n));
          send_random(n);
          drain();
          items += n;
        end
      end
    end
  endtask

  // Receiver side: toggle ready at the configured idle rate.
  initial begin : sink_side
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Compare every output transfer with the oldest owed byte.
  always @(posedge clk) begin : result_check
    coded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (coded_q.size() == 0) begin
        report_mismatch("unexpected out_byte", 32'd0, 32'(out_ch.out_byte));
      end else begin
        want = coded_q.pop_front();
        if (want.out_byte !== out_ch.out_byte) begin
          report_mismatch("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
        end
        if (want.last !== out_ch.last) begin
          report_mismatch("last", 32'(want.last), 32'(out_ch.last));
        end
      end
    end
  end

  // Hang detection: end the run after too long without any transfer.
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    // Known levels on every input from time zero.
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= ccp_pkg::REG_GEN_POLY;
    cfg_ch.data     <= '0;
    // Mirror starts at the register reset values and an empty stream.
    gen_poly    = ccp_pkg::GEN_POLY_RESET;
    gen_len     = ccp_pkg::GEN_LENGTH_RESET;
    dw_mode     = ccp_pkg::DW_MODE_RESET;
    stream_len  = ccp_pkg::INPUT_LENGTH_RESET;
    pk_bits     = '0;
    pk_cnt      = '0;
    pk_seen     = '0;
    pk_hdr_sent = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_nibble_mode();
    test_clamped_generator();
    test_stream_lengths();
    test_random_streams();

    if (coded_q.size() != 0) begin
      report_mismatch("bytes never delivered", 32'(coded_q.size()), 32'd0);
    end
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
